FILE: design/moving_average_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Moving average filter assertion macros
// Concurrent assertion wrappers that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_CORE_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MAF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("moving average filter: assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average filter: sequence check failed");
`else
`define MAF_ASSERT(lbl, clk, rst_n, prop)
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/maf_pkg.sv
// ----------------------------------------------------------------------------
// Moving average filter package
// Fixed widths, register map and reset values shared by the filter modules.
// ----------------------------------------------------------------------------
package maf_pkg;

    // Width of the window length register and of the divisor.
    localparam int LEN_W = 5;
    // Result format: signed Q.8 in 24 bits.
    localparam int OUT_BITS = 24;
    localparam int Q_FRAC_BITS = 8;

    // Register port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_WINDOW_LEN = 1'b0;

    localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 5'd4;

endpackage

FILE: design/maf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/maf_div.sv
// ----------------------------------------------------------------------------
// Moving average filter divider
// Restoring unsigned divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module maf_div
    import maf_pkg::*;
#(
    parameter int DIV_W = 29
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [LEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [LEN_W:0]   rem_sh;
    logic [LEN_W:0]   rem_diff;
    logic             ge;

    // The remainder stays below the divisor, so the shifted value fits in
    // one extra bit and the difference fits back into the remainder.
    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign ge       = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/moving_average_filter_core.sv
// ----------------------------------------------------------------------------
// Moving average filter core
// Sliding-window average of signed samples, result in signed Q.8.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one sample. The last window_len
// samples sit in a small RAM ring next to a running sum. While the window is
// filling, a sample yields no result; the sample that fills it and every later
// one yields one average, (sum * 256) / window_len truncated toward zero, in
// these steps: accept the sample, read the oldest sample from the ring and
// update the sum, launch the division, run the bit-serial divider, and hand
// the result to the output register. A finished result waits in the output
// register while the next sample is already taken. A write to window_len
// restarts the fill from empty.
// ----------------------------------------------------------------------------
`include "moving_average_filter_core_defines.svh"

module moving_average_filter_core
    import maf_pkg::*;
#(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [OUT_BITS-1:0]    o_average_q8,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    // Up to 31 samples can be summed.
    localparam int SUM_W = SAMPLE_BITS + LEN_W;
    localparam int DIV_W = SUM_W + Q_FRAC_BITS;
    localparam int EXT_W = ((DIV_W > OUT_BITS) ? DIV_W : OUT_BITS) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [LEN_W-1:0]        r_window_len;
    logic [PTR_W-1:0]        r_wp, n_wp;
    logic [LEN_W-1:0]        r_fill, n_fill;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [PTR_W-1:0]        r_slot;
    logic [SAMPLE_BITS-1:0]  r_sample;
    logic                    r_neg;
    logic [OUT_BITS-1:0]     r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]     r_out;

    logic                    cfg_wr;
    logic                    in_xfer;
    logic                    out_free;
    logic [LEN_W-1:0]        eff_len;
    logic [PTR_W-1:0]        slot;
    logic [PTR_W-1:0]        next_ptr;
    logic                    full;
    logic [SAMPLE_BITS-1:0]  ram_rd_data;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] new_ext;
    logic signed [DIV_W-1:0] scaled;
    logic [DIV_W-1:0]        dividend;
    logic                    div_done;
    logic [DIV_W-1:0]        quotient;
    logic [EXT_W-1:0]        q_ext;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN)
                    ? APB_DATA_W'(r_window_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RESET;
        end else if (cfg_wr) begin
            r_window_len <= pwdata[LEN_W-1:0];
        end
    end

    // A length of zero acts as one; anything above the ring depth saturates.
    always_comb begin
        if (r_window_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_window_len) > 32'(WINDOW_MAX)) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = r_window_len;
        end
    end

    // ------------------------------------------------------------------
    // Ring addressing
    // ------------------------------------------------------------------
    assign slot     = (32'(r_wp) >= 32'(eff_len)) ? '0 : r_wp;
    assign next_ptr = (32'(r_slot) + 32'd1 >= 32'(eff_len))
                      ? '0 : PTR_W'(32'(r_slot) + 32'd1);
    assign full     = (r_fill >= eff_len);

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_READ),
        .i_wr_addr (r_slot),
        .i_wr_data (r_sample),
        .i_rd_en   (in_xfer),
        .i_rd_addr (slot),
        .o_rd_data (ram_rd_data)
    );

    assign old_ext = {{(SUM_W-SAMPLE_BITS){ram_rd_data[SAMPLE_BITS-1]}}, ram_rd_data};
    assign new_ext = {{(SUM_W-SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};

    // ------------------------------------------------------------------
    // Division of the scaled sum by the window length
    // ------------------------------------------------------------------
    assign scaled   = {r_sum, {Q_FRAC_BITS{1'b0}}};
    assign dividend = scaled[DIV_W-1] ? DIV_W'(-scaled) : DIV_W'(scaled);

    maf_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_START),
        .i_dividend (dividend),
        .i_divisor  (eff_len),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign q_ext = EXT_W'(quotient);

    // Saturate the magnitude to the signed output range, then apply the sign.
    always_comb begin
        if (r_neg) begin
            if (q_ext > EXT_W'(2 ** (OUT_BITS - 1))) begin
                n_res = {1'b1, {(OUT_BITS-1){1'b0}}};
            end else begin
                n_res = OUT_BITS'(-q_ext);
            end
        end else begin
            if (q_ext > EXT_W'(2 ** (OUT_BITS - 1) - 1)) begin
                n_res = {1'b0, {(OUT_BITS-1){1'b1}}};
            end else begin
                n_res = OUT_BITS'(q_ext);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // The oldest sample leaves the sum only once the window is full.
                if (full) begin
                    n_sum   = r_sum - old_ext + new_ext;
                    n_state = ST_START;
                end else begin
                    n_sum   = r_sum + new_ext;
                    n_fill  = r_fill + 1'b1;
                    n_state = (r_fill + 1'b1 >= eff_len) ? ST_START : ST_IDLE;
                end
                n_wp = next_ptr;
            end
            ST_START: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (cfg_wr) begin
            n_wp   = '0;
            n_fill = '0;
            n_sum  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample <= i_sample;
            r_slot   <= slot;
        end
        if (r_state == ST_START) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (r_state == ST_DIV && div_done) begin
            r_res <= n_res;
        end
        if (r_state == ST_OUT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_average_q8 = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MAF_ASSERT(a_fill_bounded, i_clk, i_rst_n, r_fill <= eff_len)
    `MAF_ASSERT(a_ptr_bounded, i_clk, i_rst_n, 32'(r_wp) < 32'(eff_len))
    `MAF_ASSERT(a_div_done_in_div, i_clk, i_rst_n, !div_done || (r_state == ST_DIV))
    `MAF_ASSERT_NEXT(a_xfer_reads_ring, i_clk, i_rst_n, in_xfer, r_state == ST_READ)

endmodule
